FILE: design/tpt_pkg.sv
// Shared types and constants of the tape position tracker.
// Used by tpt_exec and tape_position_tracker_top; depends on nothing.
package tpt_pkg;

    localparam int MAX_FILES = 64;
    localparam int FILE_W    = 6;
    localparam int FT_W      = 7;
    localparam int BLK_W     = 16;
    localparam logic [BLK_W-1:0] MAX_BLOCKS = 16'hFFFF;

    typedef enum logic [3:0] {
        MODE_STATUS = 4'd0,
        MODE_REWIND = 4'd1,
        MODE_NOP    = 4'd2,
        MODE_EOM    = 4'd3,
        MODE_WEOF   = 4'd4,
        MODE_FSF    = 4'd5,
        MODE_BSF    = 4'd6,
        MODE_FSR    = 4'd7,
        MODE_BSR    = 4'd8,
        MODE_READ   = 4'd9,
        MODE_WRITE  = 4'd10,
        MODE_UNSUP  = 4'd11
    } mode_t;

    typedef enum logic [2:0] {
        OUT_OK       = 3'd0,
        OUT_NEGATIVE = 3'd1,
        OUT_HIT_END  = 3'd2,
        OUT_UNSUP    = 3'd3,
        OUT_FILEMARK = 3'd4,
        OUT_FULL     = 3'd5
    } outcome_t;

    // Current position plus the cached block count of the current file.
    typedef struct packed {
        logic [FT_W-1:0]   ft;
        logic [FILE_W-1:0] pf;
        logic [BLK_W-1:0]  pb;
        logic [BLK_W-1:0]  size;
    } pos_t;

    typedef struct packed {
        pos_t              pos;
        outcome_t          outcome;
        logic              rd_en;
        logic              pb_from_mem;
        logic              wr_en;
        logic [FILE_W-1:0] wr_addr;
        logic [BLK_W-1:0]  wr_data;
        logic              cut;
    } plan_t;

endpackage

FILE: design/tpt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tpt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/tpt_exec.sv
// Operation planner: from one command beat and the current position it works out
// the new position, the outcome and the table access. Depends on tpt_pkg.
module tpt_exec (
    input  logic [3:0]    mode,
    input  logic [31:0]   count,
    input  tpt_pkg::pos_t pos,
    output tpt_pkg::plan_t plan
);

    logic                        neg;
    logic [tpt_pkg::FILE_W-1:0]  room;
    logic [tpt_pkg::FILE_W-1:0]  want;
    logic                        over;
    logic [tpt_pkg::FT_W-1:0]    files_ahead;
    logic [tpt_pkg::BLK_W:0]     blocks_ahead;
    logic [tpt_pkg::FILE_W-1:0]  last_file;

    assign neg          = count[31];
    assign room         = tpt_pkg::FILE_W'(tpt_pkg::MAX_FILES - 1) - pos.pf;
    assign over         = count > 32'(room);
    assign want         = neg ? '0 : (over ? room : count[tpt_pkg::FILE_W-1:0]);
    assign files_ahead  = pos.ft - {1'b0, pos.pf};
    assign blocks_ahead = {1'b0, pos.size} - {1'b0, pos.pb};
    assign last_file    = tpt_pkg::FILE_W'(pos.ft - tpt_pkg::FT_W'(1));

    always_comb
    begin
        plan             = '0;
        plan.pos         = pos;
        plan.outcome     = tpt_pkg::OUT_OK;
        plan.wr_addr     = pos.pf;
        plan.wr_data     = pos.pb;
        case (tpt_pkg::mode_t'(mode))
            tpt_pkg::MODE_STATUS, tpt_pkg::MODE_NOP:
            begin
            end
            tpt_pkg::MODE_REWIND:
            begin
                plan.pos.pf = '0;
                plan.pos.pb = '0;
                plan.rd_en  = 1'b1;
            end
            tpt_pkg::MODE_EOM:
            begin
                plan.pos.pf      = last_file;
                plan.rd_en       = 1'b1;
                plan.pb_from_mem = 1'b1;
            end
            tpt_pkg::MODE_WEOF:
            begin
                // Truncate at the current block, then append empty files.
                plan.wr_en = 1'b1;
                plan.cut   = 1'b1;
                if (!neg && over)
                begin
                    plan.outcome = tpt_pkg::OUT_FULL;
                end
                plan.pos.ft = {1'b0, pos.pf} + tpt_pkg::FT_W'(1) + {1'b0, want};
                if (want != '0)
                begin
                    plan.pos.pf   = pos.pf + want;
                    plan.pos.pb   = '0;
                    plan.pos.size = '0;
                end
                else
                begin
                    plan.pos.size = pos.pb;
                end
            end
            tpt_pkg::MODE_FSF:
            begin
                if (neg)
                begin
                    plan.outcome = tpt_pkg::OUT_NEGATIVE;
                end
                else if (count < 32'(files_ahead))
                begin
                    plan.pos.pf = pos.pf + count[tpt_pkg::FILE_W-1:0];
                    plan.pos.pb = '0;
                    plan.rd_en  = 1'b1;
                end
                else
                begin
                    plan.pos.pf      = last_file;
                    plan.rd_en       = 1'b1;
                    plan.pb_from_mem = 1'b1;
                    plan.outcome     = tpt_pkg::OUT_HIT_END;
                end
            end
            tpt_pkg::MODE_BSF:
            begin
                if (neg)
                begin
                    plan.outcome = tpt_pkg::OUT_NEGATIVE;
                end
                else
                begin
                    plan.pos.pb = '0;
                    plan.rd_en  = 1'b1;
                    if (count <= 32'(pos.pf))
                    begin
                        plan.pos.pf = pos.pf - count[tpt_pkg::FILE_W-1:0];
                    end
                    else
                    begin
                        plan.pos.pf  = '0;
                        plan.outcome = tpt_pkg::OUT_HIT_END;
                    end
                end
            end
            tpt_pkg::MODE_FSR:
            begin
                if (neg)
                begin
                    plan.outcome = tpt_pkg::OUT_NEGATIVE;
                end
                else if (count <= 32'(blocks_ahead))
                begin
                    plan.pos.pb = pos.pb + count[tpt_pkg::BLK_W-1:0];
                end
                else
                begin
                    plan.pos.pb  = pos.size;
                    plan.outcome = tpt_pkg::OUT_HIT_END;
                end
            end
            tpt_pkg::MODE_BSR:
            begin
                if (neg)
                begin
                    plan.outcome = tpt_pkg::OUT_NEGATIVE;
                end
                else if (count <= 32'(pos.pb))
                begin
                    plan.pos.pb = pos.pb - count[tpt_pkg::BLK_W-1:0];
                end
                else
                begin
                    plan.pos.pb  = '0;
                    plan.outcome = tpt_pkg::OUT_HIT_END;
                end
            end
            tpt_pkg::MODE_READ:
            begin
                if (pos.pb >= pos.size)
                begin
                    plan.outcome = tpt_pkg::OUT_FILEMARK;
                    if ({1'b0, pos.pf} + tpt_pkg::FT_W'(1) < pos.ft)
                    begin
                        plan.pos.pf = pos.pf + tpt_pkg::FILE_W'(1);
                        plan.pos.pb = '0;
                        plan.rd_en  = 1'b1;
                    end
                end
                else
                begin
                    plan.pos.pb = pos.pb + tpt_pkg::BLK_W'(1);
                end
            end
            tpt_pkg::MODE_WRITE:
            begin
                plan.wr_en  = 1'b1;
                plan.cut    = 1'b1;
                plan.pos.ft = {1'b0, pos.pf} + tpt_pkg::FT_W'(1);
                if (pos.pb == tpt_pkg::MAX_BLOCKS)
                begin
                    plan.outcome  = tpt_pkg::OUT_FULL;
                    plan.pos.size = pos.pb;
                end
                else
                begin
                    plan.pos.pb   = pos.pb + tpt_pkg::BLK_W'(1);
                    plan.pos.size = pos.pb + tpt_pkg::BLK_W'(1);
                    plan.wr_data  = pos.pb + tpt_pkg::BLK_W'(1);
                end
            end
            default:
            begin
                plan.outcome = tpt_pkg::OUT_UNSUP;
            end
        endcase
    end

endmodule

FILE: design/tape_position_tracker_top.sv
// Tape position tracker: block counts per file in a RAM, position in registers.
// Depends on tpt_pkg, tpt_exec and tpt_ram.
// An accepted command beat is planned in S_IDLE, which registers the plan and issues
// the table access; S_RESP takes the read data and registers the result beat once
// the output is free. No new command is taken until that result beat is registered.
// Reset: position and file count clear at once; per-file valid bits make every
// file read as empty, so no clearing pass is needed.
module tape_position_tracker_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mode[3:0], count[35:4], zero pad[39:36]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // outcome[2:0], file_number[8:3], block_number[24:9],
                                   // at_start[25], at_file_end[26], at_tape_end[27], pad
);

    typedef enum logic {
        S_IDLE,
        S_RESP
    } state_t;

    state_t                          state_reg;
    tpt_pkg::pos_t                   pos_reg;
    tpt_pkg::plan_t                  pend_reg;
    logic [tpt_pkg::MAX_FILES-1:0]   valid_reg;
    logic [tpt_pkg::MAX_FILES-1:0]   valid_next;
    logic                            rd_valid_reg;
    logic                            m_tvalid_reg;
    logic [31:0]                     m_tdata_reg;

    tpt_pkg::plan_t                  plan;
    logic [tpt_pkg::BLK_W-1:0]       rdata;
    logic                            accept;
    logic                            out_free;
    logic                            leave;
    tpt_pkg::pos_t                   final_pos;
    logic                            fe;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign leave    = (state_reg == S_RESP) && out_free;

    tpt_exec u_exec (
        .mode  (s_tdata[3:0]),
        .count (s_tdata[35:4]),
        .pos   (pos_reg),
        .plan  (plan)
    );

    tpt_ram #(
        .WIDTH (tpt_pkg::BLK_W),
        .DEPTH (tpt_pkg::MAX_FILES)
    ) u_ram (
        .clk   (clk),
        .we    (accept && plan.wr_en),
        .waddr (plan.wr_addr),
        .wdata (plan.wr_data),
        .re    (accept && plan.rd_en),
        .raddr (plan.pos.pf),
        .rdata (rdata)
    );

    // A truncating write drops every file behind the current one.
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < tpt_pkg::MAX_FILES; i++)
        begin
            if (plan.cut && (i > int'(plan.wr_addr)))
            begin
                valid_next[i] = 1'b0;
            end
        end
        if (plan.wr_en)
        begin
            valid_next[plan.wr_addr] = 1'b1;
        end
    end

    always_comb
    begin
        final_pos = pend_reg.pos;
        if (pend_reg.rd_en)
        begin
            final_pos.size = rd_valid_reg ? rdata : '0;
        end
        if (pend_reg.pb_from_mem)
        begin
            final_pos.pb = final_pos.size;
        end
    end

    assign fe = (final_pos.pb == final_pos.size);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pos_reg      <= '{ft: tpt_pkg::FT_W'(1), default: '0};
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            pend_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        pend_reg   <= plan;
                        pos_reg.pf <= plan.pos.pf;
                        pos_reg.ft <= plan.pos.ft;
                        valid_reg  <= valid_next;
                        if (plan.rd_en)
                        begin
                            rd_valid_reg <= valid_reg[plan.pos.pf];
                        end
                        state_reg <= S_RESP;
                    end
                end
                S_RESP:
                begin
                    if (leave)
                    begin
                        pos_reg.pb   <= final_pos.pb;
                        pos_reg.size <= final_pos.size;
                        m_tdata_reg  <= {4'b0000,
                                         fe && ({1'b0, final_pos.pf} + tpt_pkg::FT_W'(1)
                                                == final_pos.ft),
                                         fe,
                                         (final_pos.pf == '0) && (final_pos.pb == '0),
                                         final_pos.pb,
                                         final_pos.pf,
                                         pend_reg.outcome};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (leave)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The current file always lies on the tape.
    a_file_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, pos_reg.pf} < pos_reg.ft))
        else $error("current file beyond file count");

    // While idle, the block position never passes the cached size of its file.
    a_block_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (pos_reg.pb <= pos_reg.size))
        else $error("block position beyond end of file");

    // A result beat only appears after the response cycle of a command.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_RESP))
        else $error("result beat without a command");

    // A command is taken only when no other command is in flight.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_RESP))
        else $error("command accepted out of turn");

endmodule

FILE: bench/tape_position_tracker_top_test.sv
// Self-checking bench for tape_position_tracker_top over its command and status streams.
// Depends on tpt_pkg and the tracker RTL; a built-in position model predicts every status beat.
`timescale 1ns / 1ps

module tape_position_tracker_top_test;

    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int QUIET_ITEMS = 200;
    localparam int MAX_REPORTS = 10;
    localparam logic [3:0] MODE_LAST_CODE = 4'hF;
    localparam logic [31:0] COUNT_MAX_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] COUNT_MIN_NEG = 32'h8000_0000;
    localparam logic [31:0] COUNT_MINUS_ONE = 32'hFFFF_FFFF;

    typedef struct packed {
        tpt_pkg::outcome_t          outcome;
        logic [tpt_pkg::FILE_W-1:0] file_no;
        logic [tpt_pkg::BLK_W-1:0]  block_no;
        logic                       at_start;
        logic                       at_file_end;
        logic                       at_tape_end;
    } tape_status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    // Model of the tape: block count per file and the current position.
    logic [tpt_pkg::BLK_W-1:0]  file_blocks [tpt_pkg::MAX_FILES];
    logic [tpt_pkg::FT_W-1:0]   files_on_tape;
    logic [tpt_pkg::FILE_W-1:0] cur_file;
    logic [tpt_pkg::BLK_W-1:0]  cur_block;

    tape_status_t expected_status [$];
    int  failures = 0;
    int  commands_sent = 0;
    int  beats_checked = 0;
    int  outcome_seen [6];
    int  idle_cycles = 0;
    int  ready_hold = 0;
    bit  quiet = 1'b0;

    tape_position_tracker_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    function automatic void note_failure(string msg);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("MISMATCH: %s", msg);
    endfunction

    function automatic string show_status(tape_status_t st);
        return $sformatf("oc=%0d file=%0d blk=%0d flags=%b%b%b", st.outcome, st.file_no,
                         st.block_no, st.at_start, st.at_file_end, st.at_tape_end);
    endfunction

    function automatic void clear_tape();
        for (int i = 0; i < tpt_pkg::MAX_FILES; i++)
            file_blocks[i] = '0;
        files_on_tape = tpt_pkg::FT_W'(1);
        cur_file = '0;
        cur_block = '0;
    endfunction

    // A write drops everything behind the current position.
    function automatic void truncate_tape();
        file_blocks[cur_file] = cur_block;
        for (int i = 0; i < tpt_pkg::MAX_FILES; i++)
            if (i > cur_file)
                file_blocks[i] = '0;
        files_on_tape = {1'b0, cur_file} + tpt_pkg::FT_W'(1);
    endfunction

    function automatic tape_status_t track_position(logic [3:0] mode, logic [31:0] count);
        tape_status_t               st;
        logic                       neg;
        logic [33:0]                n;
        logic [33:0]                marks;
        logic [33:0]                room;
        logic [tpt_pkg::BLK_W-1:0]  size;
        tpt_pkg::outcome_t          oc;
        neg = count[31];
        n = {2'b00, count};
        size = file_blocks[cur_file];
        oc = tpt_pkg::OUT_OK;
        case (mode)
            tpt_pkg::MODE_STATUS, tpt_pkg::MODE_NOP: ;
            tpt_pkg::MODE_REWIND:
            begin
                cur_file = '0;
                cur_block = '0;
            end
            tpt_pkg::MODE_EOM:
            begin
                cur_file = tpt_pkg::FILE_W'(files_on_tape - tpt_pkg::FT_W'(1));
                cur_block = file_blocks[cur_file];
            end
            tpt_pkg::MODE_WEOF:
            begin
                marks = neg ? '0 : n;
                truncate_tape();
                room = 34'(tpt_pkg::MAX_FILES) - 34'(files_on_tape);
                if (marks > room)
                begin
                    marks = room;
                    oc = tpt_pkg::OUT_FULL;
                end
                if (marks > 0)
                begin
                    files_on_tape = files_on_tape + marks[tpt_pkg::FT_W-1:0];
                    cur_file = cur_file + marks[tpt_pkg::FILE_W-1:0];
                    cur_block = '0;
                end
            end
            tpt_pkg::MODE_FSF:
            begin
                if (neg) oc = tpt_pkg::OUT_NEGATIVE;
                else if (cur_file + n < files_on_tape)
                begin
                    cur_file = cur_file + n[tpt_pkg::FILE_W-1:0];
                    cur_block = '0;
                end
                else
                begin
                    cur_file = tpt_pkg::FILE_W'(files_on_tape - tpt_pkg::FT_W'(1));
                    cur_block = file_blocks[cur_file];
                    oc = tpt_pkg::OUT_HIT_END;
                end
            end
            tpt_pkg::MODE_BSF:
            begin
                if (neg) oc = tpt_pkg::OUT_NEGATIVE;
                else if (cur_file >= n)
                begin
                    cur_file = cur_file - n[tpt_pkg::FILE_W-1:0];
                    cur_block = '0;
                end
                else
                begin
                    cur_file = '0;
                    cur_block = '0;
                    oc = tpt_pkg::OUT_HIT_END;
                end
            end
            tpt_pkg::MODE_FSR:
            begin
                if (neg) oc = tpt_pkg::OUT_NEGATIVE;
                else if (cur_block + n <= size)
                    cur_block = cur_block + n[tpt_pkg::BLK_W-1:0];
                else
                begin
                    cur_block = size;
                    oc = tpt_pkg::OUT_HIT_END;
                end
            end
            tpt_pkg::MODE_BSR:
            begin
                if (neg) oc = tpt_pkg::OUT_NEGATIVE;
                else if (cur_block >= n) cur_block = cur_block - n[tpt_pkg::BLK_W-1:0];
                else
                begin
                    cur_block = '0;
                    oc = tpt_pkg::OUT_HIT_END;
                end
            end
            tpt_pkg::MODE_READ:
            begin
                if (cur_block >= size)
                begin
                    if ({1'b0, cur_file} + tpt_pkg::FT_W'(1) < files_on_tape)
                    begin
                        cur_file = cur_file + tpt_pkg::FILE_W'(1);
                        cur_block = '0;
                    end
                    oc = tpt_pkg::OUT_FILEMARK;
                end
                else
                begin
                    cur_block = cur_block + tpt_pkg::BLK_W'(1);
                end
            end
            tpt_pkg::MODE_WRITE:
            begin
                truncate_tape();
                if (cur_block == tpt_pkg::MAX_BLOCKS) oc = tpt_pkg::OUT_FULL;
                else
                begin
                    cur_block = cur_block + tpt_pkg::BLK_W'(1);
                    file_blocks[cur_file] = cur_block;
                end
            end
            default: oc = tpt_pkg::OUT_UNSUP;
        endcase
        st.outcome = oc;
        st.file_no = cur_file;
        st.block_no = cur_block;
        st.at_start = (cur_file == 0) && (cur_block == 0);
        st.at_file_end = cur_block == file_blocks[cur_file];
        st.at_tape_end = st.at_file_end
                         && ({1'b0, cur_file} + tpt_pkg::FT_W'(1) == files_on_tape);
        return st;
    endfunction

    // Drives one command beat from a falling edge and returns at the edge that takes it.
    task automatic issue_command(logic [3:0] mode, logic [31:0] count);
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0000, count, mode};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_status.insert(expected_status.size(), track_position(mode, count));
        commands_sent++;
    endtask

    task automatic hold_commands();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain_status();
        hold_commands();
        wait (expected_status.size() == 0);
    endtask

    function automatic logic [31:0] random_count();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return $urandom_range(0, 4);
        if (pick < 80) return $urandom_range(0, 70);
        if (pick < 88) return $urandom | COUNT_MIN_NEG;
        if (pick < 94) return $urandom;
        case ($urandom_range(0, 3))
            0: return '0;
            1: return COUNT_MAX_POS;
            2: return COUNT_MIN_NEG;
            default: return COUNT_MINUS_ONE;
        endcase
    endfunction

    function automatic logic [3:0] random_mode();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) return tpt_pkg::MODE_WRITE;
        if (pick < 30) return tpt_pkg::MODE_WEOF;
        if (pick < 40) return tpt_pkg::MODE_FSF;
        if (pick < 50) return tpt_pkg::MODE_BSF;
        if (pick < 58) return tpt_pkg::MODE_FSR;
        if (pick < 66) return tpt_pkg::MODE_BSR;
        if (pick < 80) return tpt_pkg::MODE_READ;
        if (pick < 84) return tpt_pkg::MODE_REWIND;
        if (pick < 87) return tpt_pkg::MODE_EOM;
        if (pick < 90) return tpt_pkg::MODE_STATUS;
        if (pick < 92) return tpt_pkg::MODE_NOP;
        return 4'($urandom_range(tpt_pkg::MODE_UNSUP, MODE_LAST_CODE));
    endfunction

    task automatic test_empty_tape();
        issue_command(tpt_pkg::MODE_STATUS, '0);
        issue_command(tpt_pkg::MODE_NOP, COUNT_MINUS_ONE);
        issue_command(tpt_pkg::MODE_EOM, '0);
        issue_command(tpt_pkg::MODE_READ, '0);
        issue_command(tpt_pkg::MODE_REWIND, COUNT_MAX_POS);
    endtask

    task automatic test_unsupported_modes();
        for (int m = tpt_pkg::MODE_UNSUP; m <= MODE_LAST_CODE; m++)
            issue_command(4'(m), $urandom);
    endtask

    task automatic test_negative_counts();
        issue_command(tpt_pkg::MODE_WRITE, '0);
        issue_command(tpt_pkg::MODE_FSF, COUNT_MIN_NEG);
        issue_command(tpt_pkg::MODE_BSF, COUNT_MINUS_ONE);
        issue_command(tpt_pkg::MODE_FSR, COUNT_MIN_NEG);
        issue_command(tpt_pkg::MODE_BSR, COUNT_MINUS_ONE);
        // A negative filemark count still cuts the tape at the current block.
        issue_command(tpt_pkg::MODE_REWIND, '0);
        issue_command(tpt_pkg::MODE_WEOF, COUNT_MINUS_ONE);
    endtask

    task automatic test_spacing();
        issue_command(tpt_pkg::MODE_REWIND, '0);
        repeat (3) issue_command(tpt_pkg::MODE_WRITE, '0);
        issue_command(tpt_pkg::MODE_WEOF, 32'd1);
        repeat (2) issue_command(tpt_pkg::MODE_WRITE, '0);
        issue_command(tpt_pkg::MODE_WEOF, 32'd2);
        issue_command(tpt_pkg::MODE_REWIND, '0);
        issue_command(tpt_pkg::MODE_FSF, 32'd2);
        issue_command(tpt_pkg::MODE_FSF, COUNT_MAX_POS);
        issue_command(tpt_pkg::MODE_BSF, 32'd1);
        issue_command(tpt_pkg::MODE_FSF, '0);
        issue_command(tpt_pkg::MODE_BSF, COUNT_MAX_POS);
        issue_command(tpt_pkg::MODE_FSR, 32'd2);
        issue_command(tpt_pkg::MODE_FSR, COUNT_MAX_POS);
        issue_command(tpt_pkg::MODE_READ, '0);
        issue_command(tpt_pkg::MODE_READ, '0);
        issue_command(tpt_pkg::MODE_BSR, 32'd1);
        issue_command(tpt_pkg::MODE_FSR, 32'd1);
        issue_command(tpt_pkg::MODE_BSR, COUNT_MAX_POS);
        issue_command(tpt_pkg::MODE_EOM, '0);
        issue_command(tpt_pkg::MODE_READ, '0);
    endtask

    task automatic test_filemark_overflow();
        issue_command(tpt_pkg::MODE_REWIND, '0);
        issue_command(tpt_pkg::MODE_WEOF, 32'd100);
        issue_command(tpt_pkg::MODE_WEOF, 32'd1);
        issue_command(tpt_pkg::MODE_WEOF, '0);
        issue_command(tpt_pkg::MODE_EOM, '0);
        issue_command(tpt_pkg::MODE_FSF, 32'd1);
        issue_command(tpt_pkg::MODE_READ, '0);
        issue_command(tpt_pkg::MODE_BSF, 32'd63);
        issue_command(tpt_pkg::MODE_WEOF, COUNT_MAX_POS);
    endtask

    task automatic test_random_commands();
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            if (k == 0 || $urandom_range(0, 149) == 0)
                drain_status();
            issue_command(random_mode(), random_count());
        end
    endtask

    // Receiver stalls in short random bursts until the quiet stretch.
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            ready_hold <= $urandom_range(0, 3);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_status
        tape_status_t got;
        tape_status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.outcome = tpt_pkg::outcome_t'(m_tdata[2:0]);
            got.file_no = m_tdata[8:3];
            got.block_no = m_tdata[24:9];
            got.at_start = m_tdata[25];
            got.at_file_end = m_tdata[26];
            got.at_tape_end = m_tdata[27];
            beats_checked++;
            if (got.outcome < 6)
                outcome_seen[got.outcome]++;
            if (expected_status.size() == 0)
            begin
                note_failure($sformatf("unexpected status beat %h", m_tdata));
            end
            else
            begin
                want = expected_status.pop_front();
                if (got.outcome !== want.outcome || got.file_no !== want.file_no
                        || got.block_no !== want.block_no || got.at_start !== want.at_start
                        || got.at_file_end !== want.at_file_end
                        || got.at_tape_end !== want.at_tape_end)
                    note_failure($sformatf("beat %0d: expected %s, got %s", beats_checked,
                                           show_status(want), show_status(got)));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout after %0d cycles without a beat", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        clear_tape();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_tape();
        test_unsupported_modes();
        test_negative_counts();
        test_spacing();
        test_filemark_overflow();
        test_random_commands();

        hold_commands();
        wait (expected_status.size() == 0);
        repeat (8) @(posedge clk);
        if (expected_status.size() != 0)
            note_failure($sformatf("%0d status beats never arrived", expected_status.size()));

        $display("Sent %0d commands across empty-tape, spacing, overflow and random runs.",
                 commands_sent);
        $display("Checked %0d beats; outcomes ok/neg/end/unsup/mark/full: %0d/%0d/%0d/%0d/%0d/%0d.",
                 beats_checked, outcome_seen[0], outcome_seen[1], outcome_seen[2],
                 outcome_seen[3], outcome_seen[4], outcome_seen[5]);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
design/tpt_pkg.sv
design/tpt_ram.sv
design/tpt_exec.sv
design/tape_position_tracker_top.sv
bench/tape_position_tracker_top_test.sv
